// ----- src/iig_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the integral image generator.
// No dependencies; imported by every module of the block but iig_ram.
package iig_pkg;

    localparam int CFG_W  = 11;   // width of a geometry register
    localparam int PIX_W  = 8;    // grayscale pixel
    localparam int SUM_W  = 32;   // wrapped integral values
    localparam int APB_AW = 3;    // two 32-bit registers
    localparam int APB_DW = 32;

    localparam logic [CFG_W-1:0] WIDTH_RESET  = 11'd640;
    localparam logic [CFG_W-1:0] HEIGHT_RESET = 11'd480;

    // Register index, taken from paddr[2]
    typedef enum logic
    {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } reg_index_t;

    typedef struct packed
    {
        logic [CFG_W-1:0] image_width;
        logic [CFG_W-1:0] image_height;
    } geometry_t;

endpackage

// ----- src/integral_image_generator.sv -----
`timescale 1ns / 1ps
// Integral image generator: top level with the pixel pipeline and line buffers.
// Depends on iig_pkg, iig_cfg and iig_ram.
//
// Usage
//   Pixels enter on the s_axis channel in raster order, one 8-bit value per
//   transaction. Each pixel yields one transaction on m_axis carrying the
//   inclusive integral value and the inclusive sum of squares, both modulo
//   2^32; m_axis_tlast marks the last pixel of a frame. Frame width and
//   height sit in two APB registers (byte addresses 0 and 4); write them only
//   while the block is idle.
//   Each pixel passes the middle stage and the output register. Throughput
//   is one pixel per clock unless the receiver stalls: a pixel reads its
//   column of the line buffers as it is accepted, and the next stage adds
//   the row sum and writes back, so each line-buffer RAM sees one read and
//   one write per cycle. When the width is one, consecutive pixels hit the
//   same entry; the value written at the accept edge is forwarded in place
//   of the stale RAM read. Reset clears the counters, running row sums and
//   pipeline valids; the line buffers are not cleared and need no clearing
//   pass, as the first row of every frame reads zero in place of them.
//   When the receiver stalls, the output register holds its transaction and
//   the middle stage holds too; s_axis_tready drops only when both are full.
module integral_image_generator
    import iig_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // pixel input
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [PIX_W-1:0]     s_axis_tdata,   // [7:0] pixel
    // integral output
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [2*SUM_W-1:0]   m_axis_tdata,   // [31:0] area_sum, [63:32] area_square_sum
    output logic                 m_axis_tlast,   // frame_end
    // configuration
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [APB_AW-1:0]    paddr,
    input  logic [APB_DW-1:0]    pwdata,
    output logic [APB_DW-1:0]    prdata,
    output logic                 pready
);

    localparam int AW    = $clog2(MAX_WIDTH);
    localparam int RW    = $clog2(MAX_HEIGHT);
    localparam int RS_W  = AW + PIX_W;          // row sum of pixels
    localparam int RSQ_W = AW + 2 * PIX_W;      // row sum of squared pixels
    // compare width: holds the register values and the maximum dimensions
    localparam int WCW   = (AW + 1 > CFG_W) ? AW + 1 : CFG_W;
    localparam int HCW   = (RW + 1 > CFG_W) ? RW + 1 : CFG_W;

    geometry_t geometry;

    iig_cfg u_cfg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .geometry (geometry)
    );

    // ------------------------------------------------------------------
    // Effective geometry: clamp to 1..MAX, express as last index
    // ------------------------------------------------------------------
    logic [WCW-1:0] width_ext;
    logic [WCW-1:0] last_col;
    logic [HCW-1:0] height_ext;
    logic [HCW-1:0] last_row;

    assign width_ext  = WCW'(geometry.image_width);
    assign height_ext = HCW'(geometry.image_height);

    always_comb
    begin
        priority if (width_ext == '0)
            last_col = '0;
        else if (width_ext > WCW'(MAX_WIDTH))
            last_col = WCW'(MAX_WIDTH - 1);
        else
            last_col = width_ext - WCW'(1);

        priority if (height_ext == '0)
            last_row = '0;
        else if (height_ext > HCW'(MAX_HEIGHT))
            last_row = HCW'(MAX_HEIGHT - 1);
        else
            last_row = height_ext - HCW'(1);
    end

    // ------------------------------------------------------------------
    // Handshake and pipeline control
    // ------------------------------------------------------------------
    logic s1_valid_reg, s1_valid_next;
    logic out_valid_reg, out_valid_next;
    logic out_free;
    logic s1_advance;
    logic accept;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s1_advance    = s1_valid_reg && out_free;   // commit: write back and emit
    assign s_axis_tready = !s1_valid_reg || out_free;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // ------------------------------------------------------------------
    // Accept stage: counters and running row sums
    // ------------------------------------------------------------------
    logic [AW-1:0]    col_reg, col_next;
    logic [RW-1:0]    row_reg, row_next;
    logic [RS_W-1:0]  row_sum_reg, row_sum_next;
    logic [RSQ_W-1:0] row_sq_reg, row_sq_next;

    logic [2*PIX_W-1:0] pix_square;
    logic [RS_W-1:0]    row_sum_acc;
    logic [RSQ_W-1:0]   row_sq_acc;
    logic               row_last;
    logic               frame_last;

    assign pix_square  = s_axis_tdata * s_axis_tdata;
    assign row_sum_acc = row_sum_reg + RS_W'(s_axis_tdata);
    assign row_sq_acc  = row_sq_reg + RSQ_W'(pix_square);
    assign row_last    = WCW'(col_reg) >= last_col;
    assign frame_last  = row_last && (HCW'(row_reg) >= last_row);

    always_comb
    begin
        col_next     = col_reg;
        row_next     = row_reg;
        row_sum_next = row_sum_reg;
        row_sq_next  = row_sq_reg;
        if (accept)
        begin
            if (row_last)
            begin
                // end of row: restart the column and the running sums
                col_next     = '0;
                row_sum_next = '0;
                row_sq_next  = '0;
                row_next     = frame_last ? '0 : row_reg + RW'(1);
            end
            else
            begin
                col_next     = col_reg + AW'(1);
                row_sum_next = row_sum_acc;
                row_sq_next  = row_sq_acc;
            end
        end
    end

    // ------------------------------------------------------------------
    // Line buffers: read the column on accept, write back on commit
    // ------------------------------------------------------------------
    logic [SUM_W-1:0] above_sum_rd;
    logic [SUM_W-1:0] above_sq_rd;
    logic [SUM_W-1:0] sum_value;
    logic [SUM_W-1:0] sq_value;
    logic [AW-1:0]    s1_addr_reg;

    iig_ram #(.WIDTH(SUM_W), .DEPTH(MAX_WIDTH)) u_sum_buf
    (
        .clk   (clk),
        .we    (s1_advance),
        .waddr (s1_addr_reg),
        .wdata (sum_value),
        .re    (accept),
        .raddr (col_reg),
        .rdata (above_sum_rd)
    );

    iig_ram #(.WIDTH(SUM_W), .DEPTH(MAX_WIDTH)) u_sq_buf
    (
        .clk   (clk),
        .we    (s1_advance),
        .waddr (s1_addr_reg),
        .wdata (sq_value),
        .re    (accept),
        .raddr (col_reg),
        .rdata (above_sq_rd)
    );

    // ------------------------------------------------------------------
    // Middle stage: add the line above to the running row sums
    // ------------------------------------------------------------------
    logic [RS_W-1:0]  s1_row_sum_reg;
    logic [RSQ_W-1:0] s1_row_sq_reg;
    logic             s1_first_row_reg;
    logic             s1_frame_end_reg;
    logic             s1_fwd_reg;
    logic [SUM_W-1:0] s1_fwd_sum_reg;
    logic [SUM_W-1:0] s1_fwd_sq_reg;
    logic [SUM_W-1:0] above_sum;
    logic [SUM_W-1:0] above_sq;
    logic             fwd_hit;

    // the entry being written at this edge is the one the new pixel reads
    assign fwd_hit = s1_advance && (s1_addr_reg == col_reg);

    always_comb
    begin
        priority if (s1_first_row_reg)
        begin
            above_sum = '0;
            above_sq  = '0;
        end
        else if (s1_fwd_reg)
        begin
            above_sum = s1_fwd_sum_reg;
            above_sq  = s1_fwd_sq_reg;
        end
        else
        begin
            above_sum = above_sum_rd;
            above_sq  = above_sq_rd;
        end
    end

    assign sum_value = above_sum + SUM_W'(s1_row_sum_reg);
    assign sq_value  = above_sq + SUM_W'(s1_row_sq_reg);

    // payload of the middle stage
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_addr_reg      <= col_reg;
            s1_row_sum_reg   <= row_sum_acc;
            s1_row_sq_reg    <= row_sq_acc;
            s1_first_row_reg <= (row_reg == '0);
            s1_frame_end_reg <= frame_last;
            s1_fwd_reg       <= fwd_hit;
            s1_fwd_sum_reg   <= sum_value;
            s1_fwd_sq_reg    <= sq_value;
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic [SUM_W-1:0] out_sum_reg;
    logic [SUM_W-1:0] out_sq_reg;
    logic             out_last_reg;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
            s1_valid_next = 1'b1;
        else if (s1_advance)
            s1_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (s1_advance)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            out_sum_reg  <= sum_value;
            out_sq_reg   <= sq_value;
            out_last_reg <= s1_frame_end_reg;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            row_sum_reg   <= '0;
            row_sq_reg    <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg       <= col_next;
            row_reg       <= row_next;
            row_sum_reg   <= row_sum_next;
            row_sq_reg    <= row_sq_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_sq_reg, out_sum_reg};
    assign m_axis_tlast  = out_last_reg;

endmodule

// ----- src/iig_ram.sv -----
`timescale 1ns / 1ps
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
module iig_ram
#(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- src/iig_cfg.sv -----
`timescale 1ns / 1ps
// APB register file holding the frame geometry.
// Depends on iig_pkg.
module iig_cfg
    import iig_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output geometry_t         geometry
);

    geometry_t  geometry_reg;
    geometry_t  geometry_next;
    reg_index_t index;
    logic       write_en;

    assign pready   = 1'b1;
    assign index    = reg_index_t'(paddr[2]);
    assign write_en = psel && penable && pwrite && pready;
    assign geometry = geometry_reg;

    always_comb
    begin
        geometry_next = geometry_reg;
        if (write_en)
        begin
            unique case (index)
                REG_IMAGE_WIDTH:  geometry_next.image_width  = pwdata[CFG_W-1:0];
                REG_IMAGE_HEIGHT: geometry_next.image_height = pwdata[CFG_W-1:0];
                default:          geometry_next = geometry_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (index)
            REG_IMAGE_WIDTH:  prdata = {{(APB_DW-CFG_W){1'b0}}, geometry_reg.image_width};
            REG_IMAGE_HEIGHT: prdata = {{(APB_DW-CFG_W){1'b0}}, geometry_reg.image_height};
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            geometry_reg.image_width  <= WIDTH_RESET;
            geometry_reg.image_height <= HEIGHT_RESET;
        end
        else
        begin
            geometry_reg <= geometry_next;
        end
    end

endmodule

// ----- tb/tb_integral_image_generator.sv -----
`timescale 1ns / 1ps
// Self-checking bench for integral_image_generator: pixel stream in, integral and
// squared-integral stream out, frame geometry over APB. Depends on iig_pkg and the RTL.
module tb_integral_image_generator;
    import iig_pkg::*;

    localparam int MAX_DIM         = 1024;  // line-buffer depth and height limit of the DUT
    localparam int SETTLE_CYCLES   = 4;     // drain margin past the middle stage and the output register
    localparam int WATCHDOG_LIMIT  = 2000;  // cycles without any transaction
    localparam int RANDOM_PER_PASS = 40;    // with the full-width frame, about 1300 pixels

    // One result transaction, laid out field by field
    typedef struct packed
    {
        logic [SUM_W-1:0] area_sum;
        logic [SUM_W-1:0] area_square_sum;
        logic             frame_end;
    } integral_t;

    // One row of the directed table: a register write or a pixel, with the
    // result typed in only where it is obvious by hand
    typedef struct packed
    {
        bit               is_cfg;
        reg_index_t       reg_sel;
        logic [31:0]      value;
        logic [PIX_W-1:0] pixel;
        bit               typed;
        integral_t        result;
    } step_t;

    logic                 clk;
    logic                 rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [PIX_W-1:0]     s_axis_tdata;    // [7:0] pixel
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [2*SUM_W-1:0]   m_axis_tdata;    // [31:0] area_sum, [63:32] area_square_sum
    logic                 m_axis_tlast;    // frame_end
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [APB_AW-1:0]    paddr;
    logic [APB_DW-1:0]    pwdata;
    logic [APB_DW-1:0]    prdata;
    logic                 pready;

    // Shadow of the block: geometry registers, running row sums, line buffers
    logic [CFG_W-1:0]     width_reg  = WIDTH_RESET;
    logic [CFG_W-1:0]     height_reg = HEIGHT_RESET;
    logic [17:0]          row_sum    = '0;
    logic [25:0]          row_sq_sum = '0;
    logic [SUM_W-1:0]     line_sums    [MAX_DIM];
    logic [SUM_W-1:0]     line_sq_sums [MAX_DIM];
    logic [9:0]           col_pos = '0;
    logic [9:0]           row_pos = '0;
    // Line-buffer entries are always written as a prefix 0..n-1; n is kept here
    // so that a mid-frame width change never reads an entry nobody wrote
    int unsigned          written_extent = 0;

    integral_t            pending_integrals [$];
    bit                   typed_pending;
    integral_t            typed_result;
    int unsigned          send_idle_pct;
    int unsigned          recv_idle_pct;
    int unsigned          stalled_cycles;
    int unsigned          mismatches;
    step_t                directed_steps [28];

    integral_image_generator dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Geometry as the block sees it: zero counts as one, oversize is clipped
    function automatic int unsigned effective_dim(input logic [CFG_W-1:0] v);
        if (v == '0)
            return 1;
        if (v > MAX_DIM)
            return MAX_DIM;
        return v;
    endfunction

    // Advance the shadow state by one pixel and return its integral values
    function automatic integral_t integrate_pixel(input logic [PIX_W-1:0] px);
        int unsigned      w;
        int unsigned      h;
        logic [SUM_W-1:0] above;
        logic [SUM_W-1:0] above_sq;
        logic             row_done;
        integral_t        r;
        w = effective_dim(width_reg);
        h = effective_dim(height_reg);
        row_sum    = row_sum + 18'(px);
        row_sq_sum = row_sq_sum + 26'(px) * 26'(px);
        // first row of a frame sees zero above it
        above    = (row_pos != 0) ? line_sums[col_pos]    : '0;
        above_sq = (row_pos != 0) ? line_sq_sums[col_pos] : '0;
        r.area_sum        = above + SUM_W'(row_sum);
        r.area_square_sum = above_sq + SUM_W'(row_sq_sum);
        line_sums[col_pos]    = r.area_sum;
        line_sq_sums[col_pos] = r.area_square_sum;
        if (col_pos + 1 > written_extent)
            written_extent = col_pos + 1;
        // counters are never cleared on a geometry change, hence "at or beyond"
        row_done    = (col_pos >= w - 1);
        r.frame_end = row_done && (row_pos >= h - 1);
        if (row_done)
        begin
            col_pos    = '0;
            row_sum    = '0;
            row_sq_sum = '0;
            row_pos    = r.frame_end ? '0 : row_pos + 1'b1;
        end
        else
        begin
            col_pos = col_pos + 1'b1;
        end
        return r;
    endfunction

    // Pixels left until the current frame closes under the present geometry
    function automatic int unsigned pixels_to_frame_end();
        int unsigned w;
        int unsigned h;
        int unsigned this_row;
        int unsigned rows_after;
        w = effective_dim(width_reg);
        h = effective_dim(height_reg);
        this_row   = (col_pos >= w - 1) ? 1 : w - col_pos;
        rows_after = (row_pos >= h - 1) ? 0 : h - 1 - row_pos;
        return this_row + rows_after * w;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH at %0t ns: %s got 0x%08h, expected 0x%08h",
                 $time, what, got, want);
        mismatches++;
    endtask

    // Scoreboard: predict on every accepted pixel, compare every accepted
    // result with the oldest prediction, and track progress for the watchdog.
    always @(posedge clk)
    begin : scoreboard
        integral_t predicted;
        integral_t wanted;
        bit        progress;
        if (rst_n)
        begin
            progress = 1'b0;
            if (psel && penable && pready)
            begin
                progress = 1'b1;
                if (pwrite)
                begin
                    case (reg_index_t'(paddr[2]))
                        REG_IMAGE_WIDTH:  width_reg  = pwdata[CFG_W-1:0];
                        REG_IMAGE_HEIGHT: height_reg = pwdata[CFG_W-1:0];
                        default: ;
                    endcase
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                progress  = 1'b1;
                predicted = integrate_pixel(s_axis_tdata);
                pending_integrals.push_back(typed_pending ? typed_result : predicted);
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                progress = 1'b1;
                if (pending_integrals.size() == 0)
                begin
                    report_mismatch("result with no pixel outstanding, area_sum",
                                    m_axis_tdata[SUM_W-1:0], '0);
                end
                else
                begin
                    wanted = pending_integrals.pop_front();
                    if (m_axis_tdata[SUM_W-1:0] !== wanted.area_sum)
                        report_mismatch("area_sum", m_axis_tdata[SUM_W-1:0],
                                        wanted.area_sum);
                    if (m_axis_tdata[2*SUM_W-1:SUM_W] !== wanted.area_square_sum)
                        report_mismatch("area_square_sum", m_axis_tdata[2*SUM_W-1:SUM_W],
                                        wanted.area_square_sum);
                    if (m_axis_tlast !== wanted.frame_end)
                        report_mismatch("frame_end", 32'(m_axis_tlast),
                                        32'(wanted.frame_end));
                end
            end
            stalled_cycles = progress ? 0 : stalled_cycles + 1;
        end
    end

    // Receiver: stall at random at the current rate, redrawn every cycle
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog: end the run when nothing has moved for too long
    initial
    begin
        while (stalled_cycles < WATCHDOG_LIMIT)
            @(posedge clk);
        $display("Simulation FAILED");
        $finish;
    end

    // All driving tasks are entered and left at a falling edge, so the state
    // read between them is settled and each input gets one update per edge.

    // Present one pixel after a random gap and hold it until accepted
    task automatic send_pixel(input logic [PIX_W-1:0] px, input bit typed,
                              input integral_t typed_value);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= px;
        typed_pending = typed;
        typed_result  = typed_value;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Drop the stream, let every outstanding result drain, then let the
    // pipeline settle
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (pending_integrals.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES)
            @(negedge clk);
    endtask

    // APB write followed by a read-back of the same register
    task automatic write_register(input reg_index_t sel, input logic [31:0] value);
        wait_idle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata !== {{(APB_DW-CFG_W){1'b0}}, value[CFG_W-1:0]})
            report_mismatch("register read-back", prdata,
                            {{(APB_DW-CFG_W){1'b0}}, value[CFG_W-1:0]});
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Random traffic: mostly whole frames with random content, with geometry
    // changes at frame ends and in mid-frame, and short broken runs between.
    task automatic run_random(input int unsigned budget);
        int unsigned      sent;
        int unsigned      n;
        int unsigned      r;
        logic [CFG_W-1:0] w;
        logic [CFG_W-1:0] h;
        logic [PIX_W-1:0] px;
        sent = 0;
        while (sent < budget)
        begin
            if ($urandom_range(99) < 40)
            begin
                r = $urandom_range(99);
                w = (r < 65) ? CFG_W'($urandom_range(1, 12)) :
                    (r < 78) ? '0 :
                    (r < 90) ? CFG_W'($urandom_range(13, 64)) :
                               CFG_W'($urandom_range(1025, 2047));
                // past the first row a wider frame reads the line buffers further out
                if (row_pos != 0 && effective_dim(w) > written_extent)
                    w = CFG_W'($urandom_range(1, written_extent));
                r = $urandom_range(99);
                h = (r < 65) ? CFG_W'($urandom_range(1, 6)) :
                    (r < 75) ? '0 :
                    (r < 88) ? CFG_W'($urandom_range(7, 40)) :
                               CFG_W'($urandom_range(1025, 2047));
                r = $urandom_range(99);
                // unused upper bits of pwdata get random junk now and then
                if (r >= 15)
                    write_register(REG_IMAGE_HEIGHT,
                                   {($urandom_range(3) == 0) ? 21'($urandom) : 21'd0, h});
                if (r < 15 || r >= 30)
                    write_register(REG_IMAGE_WIDTH,
                                   {($urandom_range(3) == 0) ? 21'($urandom) : 21'd0, w});
            end
            if ($urandom_range(99) < 70)
            begin
                n = pixels_to_frame_end();
                if ($urandom_range(1) == 1)
                    n += effective_dim(width_reg) * effective_dim(height_reg);
                if (n > 300)
                    n = $urandom_range(1, 40);
            end
            else
            begin
                n = $urandom_range(1, 40);
            end
            repeat (n)
            begin
                r  = $urandom_range(99);
                px = (r < 10) ? '0 : (r < 20) ? '1 : PIX_W'($urandom_range(255));
                send_pixel(px, 1'b0, '0);
            end
            sent += n;
        end
    endtask

    initial
    begin
        int unsigned n;
        rst_n          = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        typed_pending  = 1'b0;
        typed_result   = '0;
        send_idle_pct  = 24;
        recv_idle_pct  = 56;
        stalled_cycles = 0;
        mismatches     = 0;

        // Directed table. A 2x2 frame of extremes first; then width and height
        // of zero, which count as one, so every pixel closes its own frame; a
        // one-pixel-wide column, where each pixel lands on the entry the one
        // before has just written; then an oversize geometry cut short in
        // mid-frame, which closes the row and the frame on the next pixel.
        directed_steps = '{
            '{1'b1, REG_IMAGE_WIDTH,  32'd2, 8'd0,   1'b0, '0},
            '{1'b1, REG_IMAGE_HEIGHT, 32'd2, 8'd0,   1'b0, '0},
            '{1'b0, REG_IMAGE_WIDTH,  32'd0, 8'd255, 1'b1, '{32'd255, 32'd65025, 1'b0}},
            '{1'b0, REG_IMAGE_WIDTH,  32'd0, 8'd255, 1'b1, '{32'd510, 32'd130050, 1'b0}},
            '{1'b0, REG_IMAGE_WIDTH,  32'd0, 8'd0,   1'b1, '{32'd255, 32'd65025, 1'b0}},
            '{1'b0, REG_IMAGE_WIDTH,  32'd0, 8'd255, 1'b1, '{32'd765, 32'd195075, 1'b1}},
            '{1'b1, REG_IMAGE_WIDTH,  32'd0, 8'd0,   1'b0, '0},
            '{1'b1, REG_IMAGE_HEIGHT, 32'd0, 8'd0,   1'b0, '0},
            '{1'b0, REG_IMAGE_WIDTH,  32'd0, 8'd0,   1'b1, '{32'd0, 32'd0, 1'b1}},
            '{1'b0, REG_IMAGE_WIDTH,  32'd0, 8'd255, 1'b1, '{32'd255, 32'd65025, 1'b1}},
            '{1'b0, REG_IMAGE_WIDTH,  32'd0, 8'd1,   1'b1, '{32'd1, 32'd1, 1'b1}},
            '{1'b1, REG_IMAGE_WIDTH,  32'd1, 8'd0,   1'b0, '0},
            '{1'b1, REG_IMAGE_HEIGHT, 32'd3, 8'd0,   1'b0, '0},
            '{1'b0, REG_IMAGE_WIDTH,  32'd0, 8'd7,   1'b1, '{32'd7, 32'd49, 1'b0}},
            '{1'b0, REG_IMAGE_WIDTH,  32'd0, 8'd9,   1'b1, '{32'd16, 32'd130, 1'b0}},
            '{1'b0, REG_IMAGE_WIDTH,  32'd0, 8'd255, 1'b1, '{32'd271, 32'd65155, 1'b1}},
            '{1'b1, REG_IMAGE_WIDTH,  32'hFFFF_FFFF, 8'd0, 1'b0, '0},
            '{1'b1, REG_IMAGE_HEIGHT, 32'hFFFF_FFFF, 8'd0, 1'b0, '0},
            '{1'b0, REG_IMAGE_WIDTH,  32'd0, 8'd100, 1'b0, '0},
            '{1'b0, REG_IMAGE_WIDTH,  32'd0, 8'd200, 1'b0, '0},
            '{1'b0, REG_IMAGE_WIDTH,  32'd0, 8'd3,   1'b0, '0},
            '{1'b1, REG_IMAGE_WIDTH,  32'd3, 8'd0,   1'b0, '0},
            '{1'b1, REG_IMAGE_HEIGHT, 32'd0, 8'd0,   1'b0, '0},
            '{1'b0, REG_IMAGE_WIDTH,  32'd0, 8'd50,  1'b0, '0},
            '{1'b1, REG_IMAGE_HEIGHT, 32'd1, 8'd0,   1'b0, '0},
            '{1'b0, REG_IMAGE_WIDTH,  32'd0, 8'd255, 1'b0, '0},
            '{1'b0, REG_IMAGE_WIDTH,  32'd0, 8'd0,   1'b0, '0},
            '{1'b0, REG_IMAGE_WIDTH,  32'd0, 8'd255, 1'b0, '0}
        };

        repeat (2)
            @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_steps[i])
        begin
            if (directed_steps[i].is_cfg)
                write_register(directed_steps[i].reg_sel, directed_steps[i].value);
            else
                send_pixel(directed_steps[i].pixel, directed_steps[i].typed,
                           directed_steps[i].result);
        end

        // Full-width frame: one whole 1024-pixel row fills every line-buffer
        // entry, the next row reads them back, then shrink the width in mid-row
        write_register(REG_IMAGE_WIDTH, 32'd1024);
        write_register(REG_IMAGE_HEIGHT, 32'd2);
        repeat (MAX_DIM + 100)
            send_pixel(PIX_W'($urandom_range(255)), 1'b0, '0);
        write_register(REG_IMAGE_WIDTH, 32'd16);
        write_register(REG_IMAGE_HEIGHT, 32'd3);
        n = pixels_to_frame_end();
        repeat (n)
            send_pixel(PIX_W'($urandom_range(255)), 1'b0, '0);

        // Three passes: slow receiver, slow sender, then both flat out
        run_random(RANDOM_PER_PASS);
        send_idle_pct = 56;
        recv_idle_pct = 24;
        run_random(RANDOM_PER_PASS);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(RANDOM_PER_PASS);

        // Drain and give any stray result time to show up
        wait_idle();
        repeat (SETTLE_CYCLES)
            @(negedge clk);

        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
